// ===== rtl/erg_pkg.sv =====
package erg_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int SINE_TABLE_DEPTH = 256;

  localparam int VAL_W   = 32;
  localparam int SPAN_W  = VAL_W + 1;
  localparam int DUR_W   = 16;
  localparam int CURVE_W = 3;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_N   = SPAN_W + FRAC_BITS;
  localparam int DVS_W   = SPAN_W;
  localparam int ONE_W   = FRAC_BITS + 1;
  localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TARGET = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ABORT  = 2'd2;

  localparam logic [CURVE_W-1:0] CURVE_LIN  = 3'd0;
  localparam logic [CURVE_W-1:0] CURVE_QUAD = 3'd1;
  localparam logic [CURVE_W-1:0] CURVE_CUBE = 3'd2;
  localparam logic [CURVE_W-1:0] CURVE_SINE = 3'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DURATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START    = 2'd2;

  localparam logic [DUR_W-1:0] DURATION_RST = 16'd1000;

  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint ROUND_HALF  = 64'sd1 <<< (29 - FRAC_BITS);
  localparam longint ROUND_DIV   = 64'sd1 <<< (30 - FRAC_BITS);
  localparam longint SINE_ONE    = 64'sd1 <<< FRAC_BITS;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [DUR_W-1:0]        elapsed_ms;
    logic signed [VAL_W-1:0] target;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] eased_value;
    logic                    is_rising;
  } out_t;

  typedef struct packed {
    logic latch_in;
    logic apply;
    logic tdiv_start;
    logic tick_add;
    logic ratio;
    logic rdiv_start;
    logic rdiv_take;
    logic shape1;
    logic shape2;
    logic scale;
    logic finish;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic tick_move;
    logic bypass;
    logic r_trivial;
    logic div_done;
  } status_t;

  typedef logic [FRAC_BITS:0] sine_rom_t [0:SINE_TABLE_DEPTH];

  function automatic sine_rom_t sine_rom_build();
    sine_rom_t rom;
    longint    t;
    longint    t2;
    longint    term;
    longint    sum;
    longint    e;
    int        i;
    for (i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      t    = (Q30_HALF_PI * i) / SINE_TABLE_DEPTH;
      t2   = (t * t) / Q30_ONE;
      term = t;
      sum  = t;
      term = -((term * t2) / Q30_ONE) / 64'sd6;
      sum  = sum + term;
      term = -((term * t2) / Q30_ONE) / 64'sd20;
      sum  = sum + term;
      term = -((term * t2) / Q30_ONE) / 64'sd42;
      sum  = sum + term;
      term = -((term * t2) / Q30_ONE) / 64'sd72;
      sum  = sum + term;
      term = -((term * t2) / Q30_ONE) / 64'sd110;
      sum  = sum + term;
      term = -((term * t2) / Q30_ONE) / 64'sd156;
      sum  = sum + term;
      if (sum < 0) sum = 0;
      e = (sum + ROUND_HALF) / ROUND_DIV;
      if (e > SINE_ONE) e = SINE_ONE;
      rom[i] = e[FRAC_BITS:0];
    end
    return rom;
  endfunction

endpackage

// ===== rtl/erg_div.sv =====
module erg_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [erg_pkg::DIV_N-1:0]    dividend_i,
  input  logic [erg_pkg::DVS_W-1:0]    divisor_i,
  output logic                         done_o,
  output logic [erg_pkg::DIV_N-1:0]    quotient_o
);

  localparam int CNT_W = $clog2(erg_pkg::DIV_N + 1);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [erg_pkg::DVS_W-1:0]  rem_q, rem_d;
  logic [erg_pkg::DIV_N-1:0]  quo_q, quo_d;
  logic [erg_pkg::DVS_W-1:0]  dvs_q, dvs_d;
  logic [erg_pkg::DVS_W:0]    trial;
  logic                       ge;

  assign trial = {rem_q, quo_q[erg_pkg::DIV_N-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(erg_pkg::DIV_N);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? erg_pkg::DVS_W'(trial - {1'b0, dvs_q}) : trial[erg_pkg::DVS_W-1:0];
      quo_d = {quo_q[erg_pkg::DIV_N-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/erg_datapath.sv =====
module erg_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  erg_pkg::cmd_t                       cmd_i,
  output erg_pkg::status_t                    status_o,
  input  erg_pkg::in_t                        in_data_i,
  output erg_pkg::out_t                       out_data_o,
  input  logic                                cfg_we_i,
  input  logic [erg_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [erg_pkg::VAL_W-1:0]           cfg_wdata_i
);

  localparam int FB     = erg_pkg::FRAC_BITS;
  localparam int VW     = erg_pkg::VAL_W;
  localparam int SW     = erg_pkg::SPAN_W;
  localparam int OW     = erg_pkg::ONE_W;
  localparam int DEPTH  = erg_pkg::SINE_TABLE_DEPTH;
  localparam int IW     = erg_pkg::IDX_W;
  localparam int PROD_W = erg_pkg::DUR_W + 1 + SW;
  localparam int POS_W  = OW + IW + 1;
  localparam int IDXF_W = POS_W - FB;
  localparam int SDIF_W = OW + 1;
  localparam int SPRD_W = SDIF_W + FB + 1;
  localparam int SCL_W  = OW + 1 + SW;
  localparam int SAT_W  = 52;
  localparam erg_pkg::sine_rom_t SINE_ROM = erg_pkg::sine_rom_build();
  localparam logic [OW-1:0] ONE = OW'(1) << FB;

  function automatic logic signed [VW-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'({1'b0, {(VW-1){1'b1}}});
    lo = -hi - SAT_W'(1);
    if (v > hi) return {1'b0, {(VW-1){1'b1}}};
    if (v < lo) return {1'b1, {(VW-1){1'b0}}};
    return v[VW-1:0];
  endfunction

  logic signed [VW-1:0]              cur_q, org_q, gol_q;
  logic                              rise_q;
  logic [erg_pkg::DUR_W-1:0]         dur_q;
  logic [erg_pkg::CURVE_W-1:0]       curve_q;
  erg_pkg::in_t                      in_q;
  logic signed [PROD_W-1:0]          prod_q;
  logic [OW-1:0]                     r_q;
  logic [OW-1:0]                     sq_q;
  logic [OW-1:0]                     sa_q;
  logic signed [SPRD_W-1:0]          sprd_q;
  logic [OW-1:0]                     shaped_q;
  logic signed [SCL_W-1:0]           scl_q;
  logic signed [VW-1:0]              res_q;
  erg_pkg::out_t                     out_q;

  logic signed [SW-1:0]              span, num;
  logic [SW-1:0]                     an, ad;
  logic                              moving;
  logic [PROD_W-1:0]                 prod_mag;
  logic                              div_start;
  logic [erg_pkg::DIV_N-1:0]         div_dvd;
  logic [erg_pkg::DVS_W-1:0]         div_dvs;
  logic                              div_done;
  logic [erg_pkg::DIV_N-1:0]         div_quo;
  logic signed [erg_pkg::DIV_N:0]    delta;
  logic                              r_zero;
  logic [POS_W-1:0]                  pos;
  logic [IDXF_W-1:0]                 idx;
  logic [FB-1:0]                     frac;
  logic signed [SDIF_W-1:0]          sdif;
  logic [2*OW-1:0]                   cube;
  logic signed [SPRD_W-1:0]          sadj;
  logic signed [SDIF_W:0]            sval;
  logic signed [SCL_W-1:0]           sclb;

  assign span   = SW'(gol_q) - SW'(org_q);
  assign num    = SW'(cur_q) - SW'(org_q);
  assign an     = num[SW-1] ? SW'(-num) : num;
  assign ad     = span[SW-1] ? SW'(-span) : span;
  assign moving = (cur_q < gol_q && gol_q > org_q) || (cur_q > gol_q && gol_q < org_q);
  assign prod_mag = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : prod_q;
  assign r_zero = (num[SW-1] != span[SW-1]) || (num == '0);

  assign status_o.tick_move = (in_q.mode == erg_pkg::MODE_TICK) && moving;
  assign status_o.bypass    = !rise_q || (span == '0) || (curve_q > erg_pkg::CURVE_SINE);
  assign status_o.r_trivial = r_zero || (an >= ad);
  assign status_o.div_done  = div_done;

  assign div_start = cmd_i.tdiv_start || cmd_i.rdiv_start;
  always_comb begin
    if (cmd_i.tdiv_start) begin
      div_dvd = erg_pkg::DIV_N'(prod_mag);
      div_dvs = (dur_q == '0) ? erg_pkg::DVS_W'(1) : erg_pkg::DVS_W'(dur_q);
    end else begin
      div_dvd = {an, {FB{1'b0}}};
      div_dvs = ad;
    end
  end

  erg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign delta = prod_q[PROD_W-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

  assign pos  = POS_W'(r_q) * POS_W'(DEPTH);
  assign idx  = pos[POS_W-1:FB];
  assign frac = pos[FB-1:0];
  assign sdif = $signed({1'b0, SINE_ROM[IW'(idx) + IW'(1)]}) - $signed({1'b0, SINE_ROM[IW'(idx)]});
  assign cube = (2*OW)'(sq_q) * (2*OW)'(r_q);
  assign sadj = sprd_q + (sprd_q[SPRD_W-1] ? SPRD_W'(ONE - OW'(1)) : SPRD_W'(0));
  assign sval = $signed({2'b0, sa_q}) + SDIF_W'(sadj >>> FB);
  assign sclb = scl_q + (scl_q[SCL_W-1] ? SCL_W'(ONE - OW'(1)) : SCL_W'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      org_q   <= '0;
      gol_q   <= '0;
      rise_q  <= 1'b0;
      dur_q   <= erg_pkg::DURATION_RST;
      curve_q <= erg_pkg::CURVE_LIN;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          erg_pkg::REG_DURATION: dur_q <= cfg_wdata_i[erg_pkg::DUR_W-1:0];
          erg_pkg::REG_CURVE:    curve_q <= cfg_wdata_i[erg_pkg::CURVE_W-1:0];
          erg_pkg::REG_START: begin
            cur_q  <= cfg_wdata_i;
            org_q  <= cfg_wdata_i;
            gol_q  <= cfg_wdata_i;
            rise_q <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd_i.apply) begin
        case (in_q.mode)
          erg_pkg::MODE_TICK: begin
            if (!moving) begin
              cur_q  <= gol_q;
              org_q  <= gol_q;
              rise_q <= 1'b0;
            end
          end
          erg_pkg::MODE_TARGET: begin
            if (in_q.target == org_q && in_q.target != gol_q) begin
              org_q <= gol_q;
              gol_q <= org_q;
            end else if (in_q.target != gol_q) begin
              org_q  <= cur_q;
              gol_q  <= in_q.target;
              rise_q <= in_q.target > cur_q;
            end
          end
          erg_pkg::MODE_ABORT: begin
            org_q <= gol_q;
            gol_q <= org_q;
          end
          default: ;
        endcase
      end
      if (cmd_i.tick_add) begin
        cur_q <= sat32(SAT_W'(cur_q) + SAT_W'(delta));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) in_q <= in_data_i;
    if (cmd_i.apply) prod_q <= $signed({1'b0, in_q.elapsed_ms}) * span;
    if (cmd_i.ratio) begin
      res_q <= cur_q;
      r_q   <= r_zero ? '0 : ONE;
    end
    if (cmd_i.rdiv_take) r_q <= div_quo[OW-1:0];
    if (cmd_i.shape1) begin
      sq_q <= OW'(((2*OW)'(r_q) * (2*OW)'(r_q)) >> FB);
      if (idx >= IDXF_W'(DEPTH)) begin
        sa_q   <= SINE_ROM[DEPTH];
        sprd_q <= '0;
      end else begin
        sa_q   <= SINE_ROM[IW'(idx)];
        sprd_q <= sdif * $signed({1'b0, frac});
      end
    end
    if (cmd_i.shape2) begin
      case (curve_q)
        erg_pkg::CURVE_LIN:  shaped_q <= r_q;
        erg_pkg::CURVE_QUAD: shaped_q <= sq_q;
        erg_pkg::CURVE_CUBE: shaped_q <= OW'(cube >> FB);
        default:             shaped_q <= sval[SDIF_W] ? '0 : OW'(sval);
      endcase
    end
    if (cmd_i.scale) scl_q <= $signed({1'b0, shaped_q}) * span;
    if (cmd_i.finish) res_q <= sat32(SAT_W'(org_q) + SAT_W'(sclb >>> FB));
    if (cmd_i.out_load) begin
      out_q.eased_value <= res_q;
      out_q.is_rising   <= rise_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/erg_ctrl.sv =====
module erg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  erg_pkg::status_t  status_i,
  output erg_pkg::cmd_t     cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_APPLY  = 4'd1;
  localparam logic [3:0] S_TSTART = 4'd2;
  localparam logic [3:0] S_TDIV   = 4'd3;
  localparam logic [3:0] S_TADD   = 4'd4;
  localparam logic [3:0] S_RATIO  = 4'd5;
  localparam logic [3:0] S_RDIV   = 4'd6;
  localparam logic [3:0] S_SHAPE1 = 4'd7;
  localparam logic [3:0] S_SHAPE2 = 4'd8;
  localparam logic [3:0] S_SCALE  = 4'd9;
  localparam logic [3:0] S_FINAL  = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0] state_q, state_d;
  logic       ovld_q, ovld_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    ovld_d  = ovld_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d = status_i.tick_move ? S_TSTART : S_RATIO;
      end
      S_TSTART: begin
        cmd_o.tdiv_start = 1'b1;
        state_d = S_TDIV;
      end
      S_TDIV: if (status_i.div_done) state_d = S_TADD;
      S_TADD: begin
        cmd_o.tick_add = 1'b1;
        state_d = S_RATIO;
      end
      S_RATIO: begin
        cmd_o.ratio = 1'b1;
        if (status_i.bypass) begin
          state_d = S_OUT;
        end else if (status_i.r_trivial) begin
          state_d = S_SHAPE1;
        end else begin
          cmd_o.rdiv_start = 1'b1;
          state_d = S_RDIV;
        end
      end
      S_RDIV: begin
        if (status_i.div_done) begin
          cmd_o.rdiv_take = 1'b1;
          state_d = S_SHAPE1;
        end
      end
      S_SHAPE1: begin
        cmd_o.shape1 = 1'b1;
        state_d = S_SHAPE2;
      end
      S_SHAPE2: begin
        cmd_o.shape2 = 1'b1;
        state_d = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d = S_FINAL;
      end
      S_FINAL: begin
        cmd_o.finish = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ovld_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ovld_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovld_q;

endmodule

// ===== rtl/eased_ramp_generator.sv =====
// channel  direction  handshake              beat
// in       input      in_valid_i/in_ready_o  in_data_i  (mode, elapsed_ms, target)
// out      output     out_valid_o/out_ready_i out_data_o (eased_value, is_rising)
// cfg      input      cfg_we_i               cfg_idx_i, cfg_wdata_i
// One input beat at a time; the shortest path returns the current value as is,
// a curve that needs no division is quicker, and a moving tick with a ratio is
// slowest, set by two 49-step passes of the shared radix-2 divider.
// Output register holds the result; the next beat is taken while it waits.
// Reset is asynchronous, active low; no clearing pass.
module eased_ramp_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  erg_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output erg_pkg::out_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [erg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [erg_pkg::VAL_W-1:0]      cfg_wdata_i
);

  erg_pkg::cmd_t    cmd;
  erg_pkg::status_t status;

  erg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  erg_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule

// ===== rtl/erg_checker.sv =====
module erg_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input erg_pkg::in_t                   in_data_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input erg_pkg::out_t                  out_data_o,
  input logic                           cfg_we_i,
  input logic [erg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [erg_pkg::VAL_W-1:0]      cfg_wdata_i
);

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat dropped or changed while stalled");

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !in_ready_o ##1 !in_ready_o)
    else $error("input taken while previous beat still in work");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after input beat");

endmodule

bind eased_ramp_generator erg_checker u_erg_checker (.*);

// ===== sim/eased_ramp_generator_test.sv =====
module eased_ramp_generator_test;
  import erg_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE      = 150;
  localparam longint ONE_Q   = longint'(1) <<< FRAC_BITS;

  typedef struct {
    bit                      wr;
    logic [CFG_IDX_W-1:0]    idx;
    logic [VAL_W-1:0]        wdata;
    logic [MODE_W-1:0]       mode;
    logic [DUR_W-1:0]        ms;
    logic [VAL_W-1:0]        tgt;
    bit                      chk;
    logic [VAL_W-1:0]        ev;
    bit                      er;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [VAL_W-1:0] cfg_wdata = '0;

  logic typed_on = 1'b0;
  out_t typed_val = '0;

  logic signed [VAL_W-1:0] now_v, from_v, to_v;
  logic                    climbing;
  logic [DUR_W-1:0]        dur_r;
  logic [CURVE_W-1:0]      curve_r;
  longint                  sine_q [0:SINE_TABLE_DEPTH];

  out_t ramp_q [$];
  int   errors = 0;
  int   cycles = 0;
  int   gap_pct = 0;
  int   stall_pct = 0;

  eased_ramp_generator dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("eased_ramp_generator_test: errors");
      $finish;
    end
  end

  function automatic logic signed [VAL_W-1:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[VAL_W-1:0];
  endfunction

  function automatic void build_sine_q();
    longint t, t2, term, sum, e;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      t    = (Q30_HALF_PI * i) / SINE_TABLE_DEPTH;
      t2   = (t * t) / Q30_ONE;
      term = t;
      sum  = t;
      for (int k = 1; k <= 6; k++) begin
        term = -((term * t2) / Q30_ONE) / longint'((2 * k) * (2 * k + 1));
        sum += term;
      end
      if (sum < 0) sum = 0;
      e = (sum + (longint'(1) <<< (29 - FRAC_BITS))) / (longint'(1) <<< (30 - FRAC_BITS));
      if (e > ONE_Q) e = ONE_Q;
      sine_q[i] = e;
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] eased_now();
    longint span, num, an, ad, r, sh, pos, idx, fr, v;
    span = longint'(to_v) - longint'(from_v);
    num  = longint'(now_v) - longint'(from_v);
    if (!climbing || span == 0 || curve_r > CURVE_SINE) return now_v;
    if ((num < 0) != (span < 0) || num == 0) begin
      r = 0;
    end else begin
      an = num < 0 ? -num : num;
      ad = span < 0 ? -span : span;
      r  = (an <<< FRAC_BITS) / ad;
      if (r > ONE_Q) r = ONE_Q;
    end
    case (curve_r)
      CURVE_LIN:  sh = r;
      CURVE_QUAD: sh = (r * r) >>> FRAC_BITS;
      CURVE_CUBE: sh = (((r * r) >>> FRAC_BITS) * r) >>> FRAC_BITS;
      default: begin
        pos = r * SINE_TABLE_DEPTH;
        idx = pos >>> FRAC_BITS;
        fr  = pos & (ONE_Q - 1);
        if (idx >= SINE_TABLE_DEPTH) v = sine_q[SINE_TABLE_DEPTH];
        else v = sine_q[idx] + ((sine_q[idx+1] - sine_q[idx]) * fr) / ONE_Q;
        if (v < 0) v = 0;
        sh = v;
      end
    endcase
    return sat32(longint'(from_v) + (sh * span) / ONE_Q);
  endfunction

  function automatic out_t advance_ramp(in_t b);
    out_t   r;
    longint dur, delta;
    logic signed [VAL_W-1:0] t;
    case (b.mode)
      MODE_TICK: begin
        if ((now_v < to_v && to_v > from_v) || (now_v > to_v && to_v < from_v)) begin
          dur   = (dur_r == 0) ? 1 : longint'(dur_r);
          delta = (longint'(b.elapsed_ms) * (longint'(to_v) - longint'(from_v))) / dur;
          now_v = sat32(longint'(now_v) + delta);
        end else begin
          now_v    = to_v;
          from_v   = to_v;
          climbing = 1'b0;
        end
      end
      MODE_TARGET: begin
        if (b.target == from_v && b.target != to_v) begin
          t = from_v; from_v = to_v; to_v = t;
        end else if (b.target != to_v) begin
          from_v   = now_v;
          to_v     = b.target;
          climbing = to_v > from_v;
        end
      end
      MODE_ABORT: begin
        t = from_v; from_v = to_v; to_v = t;
      end
      default: ;
    endcase
    r.eased_value = eased_now();
    r.is_rising   = climbing;
    return r;
  endfunction

  always @(posedge clk) begin
    out_t p;
    if (rst_n && in_valid && in_ready) begin
      p = advance_ramp(in_data);
      ramp_q.push_back(typed_on ? typed_val : p);
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  task automatic report(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    out_t w;
    if (rst_n && out_valid && out_ready) begin
      if (ramp_q.size() == 0) begin
        report("unexpected beat", out_data.eased_value, '0);
      end else begin
        w = ramp_q.pop_front();
        if (out_data.eased_value !== w.eased_value)
          report("eased_value", out_data.eased_value, w.eased_value);
        if (out_data.is_rising !== w.is_rising)
          report("is_rising", out_data.is_rising, w.is_rising);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] d);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (ramp_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= d;
    case (idx)
      REG_DURATION: dur_r = d[DUR_W-1:0];
      REG_CURVE:    curve_r = d[CURVE_W-1:0];
      REG_START: begin
        now_v = d; from_v = d; to_v = d; climbing = 1'b0;
      end
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send(in_t b, bit chk, out_t ev);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= b;
    typed_on  <= chk;
    typed_val <= ev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic in_t make_beat();
    in_t b;
    int  pick;
    int  d;
    b.elapsed_ms = $urandom();
    b.target     = $urandom();
    pick = $urandom_range(99);
    if (pick < 62) begin
      b.mode = MODE_TICK;
      d = (dur_r == 0) ? 1 : dur_r;
      if ($urandom_range(9) < 7) b.elapsed_ms = $urandom_range(d / 8 + 1, 0);
    end else if (pick < 88) begin
      b.mode = MODE_TARGET;
      pick = $urandom_range(99);
      if (pick < 40) b.target = now_v + $signed($urandom_range(32'h01ffffff)) - 32'sh01000000;
      else if (pick < 52) b.target = from_v;
      else if (pick < 58) b.target = to_v;
      else if (pick < 64) b.target = 32'sh7fffffff;
      else if (pick < 70) b.target = 32'sh80000000;
      else if (pick < 85) b.target = $signed($urandom_range(16'hffff)) <<< FRAC_BITS;
    end else if (pick < 97) begin
      b.mode = MODE_ABORT;
    end else begin
      b.mode = 2'd3;
    end
    return b;
  endfunction

  plan_row_t plan [$] = '{
    '{0, REG_DURATION, 0, MODE_TICK,   0,     0,            1, 0,            0},
    '{0, REG_DURATION, 0, 2'd3,        0,     0,            1, 0,            0},
    '{0, REG_DURATION, 0, MODE_TARGET, 0,     32'h00640000, 1, 0,            1},
    '{0, REG_DURATION, 0, MODE_TICK,   500,   0,            0, 0,            0},
    '{0, REG_DURATION, 0, MODE_TICK,   65535, 0,            0, 0,            0},
    '{0, REG_DURATION, 0, MODE_ABORT,  0,     0,            0, 0,            0},
    '{0, REG_DURATION, 0, MODE_TICK,   0,     0,            0, 0,            0},
    '{0, REG_DURATION, 0, MODE_TARGET, 0,     0,            0, 0,            0},
    '{1, REG_CURVE,    CURVE_QUAD, MODE_TICK, 0, 0,         0, 0,            0},
    '{0, REG_DURATION, 0, MODE_TARGET, 0,     32'h7fffffff, 0, 0,            0},
    '{0, REG_DURATION, 0, MODE_TICK,   300,   0,            0, 0,            0},
    '{1, REG_CURVE,    CURVE_CUBE, MODE_TICK, 0, 0,         0, 0,            0},
    '{0, REG_DURATION, 0, MODE_TICK,   300,   0,            0, 0,            0},
    '{1, REG_CURVE,    CURVE_SINE, MODE_TICK, 0, 0,         0, 0,            0},
    '{0, REG_DURATION, 0, MODE_TICK,   200,   0,            0, 0,            0},
    '{0, REG_DURATION, 0, MODE_TICK,   65535, 0,            0, 0,            0},
    '{0, REG_DURATION, 0, MODE_TICK,   0,     0,            1, 32'h7fffffff, 0},
    '{1, REG_CURVE,    7, MODE_TICK,   0,     0,            0, 0,            0},
    '{1, REG_DURATION, 0, MODE_TICK,   0,     0,            0, 0,            0},
    '{0, REG_DURATION, 0, MODE_TARGET, 0,     32'h80000000, 0, 0,            0},
    '{0, REG_DURATION, 0, MODE_TICK,   1,     0,            0, 0,            0},
    '{0, REG_DURATION, 0, MODE_TICK,   0,     0,            1, 32'h80000000, 0},
    '{1, REG_START,    32'h12345678, MODE_TICK, 0, 0,       0, 0,            0},
    '{0, REG_DURATION, 0, MODE_TICK,   0,     0,            1, 32'h12345678, 0},
    '{1, REG_DURATION, 65535, MODE_TICK, 0,   0,            0, 0,            0},
    '{1, REG_CURVE,    CURVE_SINE, MODE_TICK, 0, 0,         0, 0,            0},
    '{0, REG_DURATION, 0, MODE_TARGET, 0,     32'h12340000, 0, 0,            0},
    '{0, REG_DURATION, 0, MODE_ABORT,  0,     0,            0, 0,            0},
    '{0, REG_DURATION, 0, MODE_TARGET, 0,     32'h12345678, 0, 0,            0},
    '{0, REG_DURATION, 0, MODE_TICK,   65535, 0,            0, 0,            0}
  };

  initial begin
    in_t  b;
    out_t ev;
    int   pick;
    build_sine_q();
    now_v = 0; from_v = 0; to_v = 0; climbing = 1'b0;
    dur_r = DURATION_RST; curve_r = CURVE_LIN;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_pct = 8; stall_pct = 60;
    foreach (plan[i]) begin
      if (plan[i].wr) begin
        write_reg(plan[i].idx, plan[i].wdata);
      end else begin
        b.mode = plan[i].mode; b.elapsed_ms = plan[i].ms; b.target = plan[i].tgt;
        ev.eased_value = plan[i].ev; ev.is_rising = plan[i].er;
        send(b, plan[i].chk, ev);
      end
    end

    for (int seg = 0; seg < 19; seg++) begin
      if (seg < 6) begin gap_pct = 8; stall_pct = 60; end
      else if (seg < 12) begin gap_pct = 60; stall_pct = 8; end
      else begin gap_pct = 0; stall_pct = 0; end
      pick = $urandom_range(9);
      if (pick == 0) write_reg(REG_DURATION, 0);
      else if (pick == 1) write_reg(REG_DURATION, 1);
      else if (pick == 2) write_reg(REG_DURATION, 65535);
      else write_reg(REG_DURATION, $urandom_range(4000, 1));
      write_reg(REG_CURVE, (seg < 8) ? seg : $urandom_range(7));
      pick = $urandom_range(5);
      if (pick == 0) write_reg(REG_START, $urandom());
      else if (pick == 1) write_reg(REG_START, 32'h7fffffff);
      else if (pick == 2) write_reg(REG_START, 32'h80000000);
      ev = '0;
      for (int n = 0; n < 100; n++) send(make_beat(), 1'b0, ev);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (ramp_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) $display("eased_ramp_generator_test: clean");
    else $display("eased_ramp_generator_test: errors");
    $finish;
  end

endmodule
